// ----- rtl/pcg32_pkg.sv -----
package pcg32_pkg;

  // LCG multiplier 6364136223846793005.
  localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;

  // State after reset.
  localparam logic [63:0] STATE_RESET = 64'h853C_49E6_748F_EA9B;
  localparam logic [63:0] INC_RESET   = 64'hDA3E_39CB_94B9_5BDB;

  // Command codes carried in the input beat.
  localparam logic [1:0] CMD_RESEED  = 2'd0;
  localparam logic [1:0] CMD_RAW     = 2'd1;
  localparam logic [1:0] CMD_BOUNDED = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_STREAM = 1'b1;

  // Number of restoring division steps the divider runs for one remainder.
  localparam int DIV_STEPS = 32;

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_ADD  = 9'b000100000,
    S_SEED = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  // What the current generator step belongs to.
  typedef enum logic [1:0] {
    MODE_SEED0   = 2'd0,
    MODE_SEED1   = 2'd1,
    MODE_RAW     = 2'd2,
    MODE_BOUNDED = 2'd3
  } mode_t;

endpackage

// ----- rtl/pcg32_random_generator.sv -----
// PCG32 generator with the XSH-RR output permutation.
//
// Commands arrive as beats on the s_ stream channel: command 0 reseeds the
// generator from the seed and stream registers and gives no result,
// command 1 returns one raw 32-bit draw, command 2 returns a draw below
// bound without bias. A bounded draw with bound zero returns the raw draw
// with the bound_zero flag in m_tuser set. Command 3 is dropped.
// Registers are written through the APB port: seed at address 0, stream
// select at address 8. Write them only while the block is idle.
// One generator step runs S_MUL0, S_MUL1, S_MUL2, S_ACC and S_ADD on a
// single shared 32x32 multiplier and 64-bit adder. A raw draw is one step
// and then S_EMIT, a reseed is two steps with the seed added in S_SEED
// between them, and a bounded draw runs the divider for the threshold, one
// step per tried draw, then the divider again for the final remainder.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new beat is taken while it waits; a finished result
// waits in the sequencer when that register is still full.
// Reset (synchronous, active high) restores the default state and
// increment, clears both registers and empties the output register.
module pcg32_random_generator (
  input  logic        clk,
  input  logic        rst,
  // Command beat, from bit 0 up: command[1:0], bound[33:2], zero padding.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // Result beat, from bit 0 up: value[31:0].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // Result flags, from bit 0 up: bound_zero.
  output logic [0:0]  m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  pcg32_pkg::state_t state;
  pcg32_pkg::mode_t  mode;

  logic [63:0] lcg_state;
  logic [63:0] increment;
  logic [63:0] seed_value;
  logic [62:0] stream_select;

  logic [31:0] bnd;
  logic [31:0] thr;
  logic [31:0] draw;
  logic        bz;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [4:0]  cnt;
  logic        div_final;

  logic [1:0]  in_cmd;
  logic [31:0] in_bound;
  logic        in_beat;
  logic        cfg_write;
  logic        out_free;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] add_a;
  logic [63:0] add_b;
  logic [63:0] add_sum;
  logic [32:0] div_t;
  logic [32:0] div_sub;
  logic [31:0] rem_next;
  logic [63:0] xs;
  logic [31:0] xsh;
  logic [63:0] rot_pair;
  logic [31:0] perm;

  assign in_cmd   = s_tdata[1:0];
  assign in_bound = s_tdata[33:2];
  assign s_tready = (state == pcg32_pkg::S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Configuration access: always ready, reads return the stored value.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3] == pcg32_pkg::REG_STREAM) ? {1'b0, stream_select}
                                                         : seed_value;

  // XSH-RR permutation of the current state.
  assign xs       = lcg_state ^ (lcg_state >> 18);
  assign xsh      = xs[58:27];
  assign rot_pair = {xsh, xsh} >> lcg_state[63:59];
  assign perm     = rot_pair[31:0];

  // Operand selection for the shared multiplier: low x low, high x low,
  // low x high. The high x high product falls outside 64 bits.
  always_comb begin
    case (state)
      pcg32_pkg::S_MUL1: begin
        mul_a = lcg_state[63:32];
        mul_b = pcg32_pkg::LCG_MULT[31:0];
      end
      pcg32_pkg::S_MUL2: begin
        mul_a = lcg_state[31:0];
        mul_b = pcg32_pkg::LCG_MULT[63:32];
      end
      default: begin
        mul_a = lcg_state[31:0];
        mul_b = pcg32_pkg::LCG_MULT[31:0];
      end
    endcase
  end

  // Shared 64-bit adder: increment after the multiply, or seed on reseed.
  assign add_a   = (state == pcg32_pkg::S_SEED) ? lcg_state : acc;
  assign add_b   = (state == pcg32_pkg::S_SEED) ? seed_value : (increment | 64'd1);
  assign add_sum = add_a + add_b;

  // One restoring division step per cycle.
  assign div_t    = {rem, quo[31]};
  assign div_sub  = div_t - {1'b0, bnd};
  assign rem_next = (div_t >= {1'b0, bnd}) ? div_sub[31:0] : div_t[31:0];

  // Sequencer, generator state, registers and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pcg32_pkg::S_IDLE;
      mode          <= pcg32_pkg::MODE_RAW;
      lcg_state     <= pcg32_pkg::STATE_RESET;
      increment     <= pcg32_pkg::INC_RESET;
      seed_value    <= 64'd0;
      stream_select <= 63'd0;
      m_tvalid      <= 1'b0;
      div_final     <= 1'b0;
      cnt           <= 5'd0;
    end else begin
      if (cfg_write) begin
        if (paddr[3] == pcg32_pkg::REG_SEED) begin
          seed_value <= pwdata;
        end else begin
          stream_select <= pwdata[62:0];
        end
      end

      // A beat taken while a new result is loaded keeps the output valid.
      if (m_tvalid && m_tready && state != pcg32_pkg::S_EMIT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        pcg32_pkg::S_IDLE: begin
          if (in_beat) begin
            case (in_cmd)
              pcg32_pkg::CMD_RESEED: begin
                lcg_state <= 64'd0;
                increment <= {stream_select, 1'b1};
                mode      <= pcg32_pkg::MODE_SEED0;
                state     <= pcg32_pkg::S_MUL0;
              end
              pcg32_pkg::CMD_RAW: begin
                mode  <= pcg32_pkg::MODE_RAW;
                state <= pcg32_pkg::S_MUL0;
              end
              pcg32_pkg::CMD_BOUNDED: begin
                if (in_bound == 32'd0) begin
                  mode  <= pcg32_pkg::MODE_RAW;
                  state <= pcg32_pkg::S_MUL0;
                end else begin
                  mode      <= pcg32_pkg::MODE_BOUNDED;
                  div_final <= 1'b0;
                  cnt       <= 5'd0;
                  state     <= pcg32_pkg::S_DIV;
                end
              end
              default: begin
                state <= pcg32_pkg::S_IDLE;
              end
            endcase
          end
        end
        pcg32_pkg::S_MUL0: state <= pcg32_pkg::S_MUL1;
        pcg32_pkg::S_MUL1: state <= pcg32_pkg::S_MUL2;
        pcg32_pkg::S_MUL2: state <= pcg32_pkg::S_ACC;
        pcg32_pkg::S_ACC:  state <= pcg32_pkg::S_ADD;
        pcg32_pkg::S_ADD: begin
          lcg_state <= add_sum;
          case (mode)
            pcg32_pkg::MODE_SEED0: state <= pcg32_pkg::S_SEED;
            pcg32_pkg::MODE_SEED1: state <= pcg32_pkg::S_IDLE;
            pcg32_pkg::MODE_RAW:   state <= pcg32_pkg::S_EMIT;
            default: begin
              // Reject draws under the threshold and try again.
              if (draw >= thr) begin
                div_final <= 1'b1;
                cnt       <= 5'd0;
                state     <= pcg32_pkg::S_DIV;
              end else begin
                state <= pcg32_pkg::S_MUL0;
              end
            end
          endcase
        end
        pcg32_pkg::S_SEED: begin
          lcg_state <= add_sum;
          mode      <= pcg32_pkg::MODE_SEED1;
          state     <= pcg32_pkg::S_MUL0;
        end
        pcg32_pkg::S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(pcg32_pkg::DIV_STEPS - 1)) begin
            state <= div_final ? pcg32_pkg::S_EMIT : pcg32_pkg::S_MUL0;
          end
        end
        pcg32_pkg::S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= pcg32_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pcg32_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: products, accumulator, divider and result payload.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (in_beat) begin
      bnd  <= in_bound;
      bz   <= (in_cmd == pcg32_pkg::CMD_BOUNDED) && (in_bound == 32'd0);
      quo  <= ~in_bound + 32'd1;
      rem  <= 32'd0;
    end

    case (state)
      pcg32_pkg::S_MUL0: draw <= perm;
      pcg32_pkg::S_MUL1: acc <= prod;
      pcg32_pkg::S_MUL2: acc[63:32] <= acc[63:32] + prod[31:0];
      pcg32_pkg::S_ACC:  acc[63:32] <= acc[63:32] + prod[31:0];
      pcg32_pkg::S_ADD: begin
        if (mode == pcg32_pkg::MODE_BOUNDED) begin
          quo <= draw;
          rem <= 32'd0;
        end
      end
      pcg32_pkg::S_DIV: begin
        rem <= rem_next;
        quo <= {quo[30:0], 1'b0};
        if (cnt == 5'(pcg32_pkg::DIV_STEPS - 1)) begin
          if (div_final) begin
            draw <= rem_next;
          end else begin
            thr <= rem_next;
          end
        end
      end
      pcg32_pkg::S_EMIT: begin
        if (out_free) begin
          m_tdata <= draw;
          m_tuser <= bz;
        end
      end
      default: begin
      end
    endcase
  end

  // The increment used by the LCG is always odd.
  a_inc_odd: assert property (@(posedge clk) disable iff (rst) increment[0])
    else $error("increment became even");

  // Any real command leaves the sequencer busy on the next cycle.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_cmd != pcg32_pkg::CMD_NOP) |=> !s_tready)
    else $error("sequencer idle right after a command beat");

  // The rejection threshold is always below the bound.
  a_thr_below_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pcg32_pkg::S_MUL0 && mode == pcg32_pkg::MODE_BOUNDED) |-> (thr < bnd))
    else $error("threshold not below bound");

  // A bounded result loaded into the output register lies below the bound.
  a_value_below_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pcg32_pkg::S_EMIT && mode == pcg32_pkg::MODE_BOUNDED && out_free)
    |=> (m_tdata < bnd))
    else $error("bounded value not below bound");

  // The divider runs its full count before leaving.
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == pcg32_pkg::S_DIV && cnt != 5'(pcg32_pkg::DIV_STEPS - 1))
    |=> (state == pcg32_pkg::S_DIV))
    else $error("divider left early");

endmodule

// ----- verif/pcg32_random_generator_tb.sv -----
`timescale 1ns / 1ps

module pcg32_random_generator_tb;

  localparam logic [3:0] ADDR_SEED   = {pcg32_pkg::REG_SEED, 3'b000};
  localparam logic [3:0] ADDR_STREAM = {pcg32_pkg::REG_STREAM, 3'b000};
  localparam int PHASE_ITEMS = 475;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 2000000;

  // Predicts PCG32 draws and holds the results still to come out of the block.
  class pcg32_scoreboard;
    logic [63:0] lcg_state;
    logic [63:0] increment;
    logic [63:0] seed;
    logic [62:0] stream;
    logic [31:0] value_q[$];
    logic        flag_q[$];
    int errors;
    int n_raw;
    int n_bounded;
    int n_zero;
    int n_reseed;
    int n_checked;

    function new();
      lcg_state = 64'h853C_49E6_748F_EA9B;
      increment = 64'hDA3E_39CB_94B9_5BDB;
      seed      = '0;
      stream    = '0;
      errors    = 0;
      n_raw     = 0;
      n_bounded = 0;
      n_zero    = 0;
      n_reseed  = 0;
      n_checked = 0;
    endfunction

    // One generator step: XSH-RR output from the old state, then the LCG advance.
    function logic [31:0] advance();
      logic [63:0] old;
      logic [63:0] mixed;
      logic [31:0] x;
      logic [63:0] twin;
      old = lcg_state;
      lcg_state = old * 64'd6364136223846793005 + (increment | 64'd1);
      mixed = ((old >> 18) ^ old) >> 27;
      x = mixed[31:0];
      twin = {x, x} >> old[63:59];
      return twin[31:0];
    endfunction

    function void write_reg(logic [3:0] addr, logic [63:0] data);
      if (addr == ADDR_SEED) begin
        seed = data;
      end else if (addr == ADDR_STREAM) begin
        stream = data[62:0];
      end
    endfunction

    function int pending();
      return value_q.size();
    endfunction

    // Note one accepted command beat and queue what it should produce.
    function void note_command(logic [1:0] cmd, logic [31:0] bnd);
      logic [31:0] thr;
      logic [31:0] r;
      case (cmd)
        pcg32_pkg::CMD_RESEED: begin
          lcg_state = '0;
          increment = {stream, 1'b1};
          void'(advance());
          lcg_state = lcg_state + seed;
          void'(advance());
          n_reseed++;
        end
        pcg32_pkg::CMD_RAW: begin
          value_q.push_back(advance());
          flag_q.push_back(1'b0);
          n_raw++;
        end
        pcg32_pkg::CMD_BOUNDED: begin
          n_bounded++;
          if (bnd == 32'd0) begin
            // A zero bound returns the raw draw and raises the flag.
            value_q.push_back(advance());
            flag_q.push_back(1'b1);
            n_zero++;
          end else begin
            // Reject draws below (2^32 - bound) mod bound to avoid bias.
            thr = (32'd0 - bnd) % bnd;
            r = advance();
            while (r < thr) r = advance();
            value_q.push_back(r % bnd);
            flag_q.push_back(1'b0);
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(logic [31:0] value, logic flag);
      logic [31:0] exp_value;
      logic        exp_flag;
      if (value_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h bound_zero=%b", $time, value, flag);
        return;
      end
      exp_value = value_q.pop_front();
      exp_flag = flag_q.pop_front();
      n_checked++;
      if (value !== exp_value) begin
        errors++;
        $display("%0t: value mismatch, expected %h, got %h", $time, exp_value, value);
      end
      if (flag !== exp_flag) begin
        errors++;
        $display("%0t: bound_zero mismatch, expected %b, got %b", $time, exp_flag, flag);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // Command beat, from bit 0 up: command[1:0], bound[33:2], zero padding.
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // Result beat, from bit 0 up: value[31:0].
  logic [31:0] m_tdata;
  // Result flags, from bit 0 up: bound_zero.
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  pcg32_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  pcg32_random_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Result side: random stalls and a check of every accepted beat.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser[0]);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.", cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one command beat, with random idle cycles ahead of it.
  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] bnd);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b000000, bnd, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, bnd);
  endtask

  // Register write with a setup phase and then an access phase.
  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(addr, data);
  endtask

  // Drain all results, then let a trailing reseed or ignored beat finish.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bounds drawn from several families: full range, small, powers of two,
  // heavy rejection just above 2^31, near the top, and the zero bound.
  function automatic logic [31:0] pick_bound();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(16, 1);
      2: return 32'd1 << $urandom_range(31);
      3: return 32'h8000_0000 + $urandom_range(4096);
      4: return 32'hFFFF_FFFF - $urandom_range(255);
      default: return ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1000);
    endcase
  endfunction

  initial begin
    int ph;
    int sent;
    int roll;
    logic [1:0] cmd;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: draws from the default state, special bounds, ignored beat, reseed.
    send_cmd(pcg32_pkg::CMD_RAW, 32'd0);
    send_cmd(pcg32_pkg::CMD_RAW, 32'hFFFF_FFFF);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'd0);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'd1);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'hFFFF_FFFF);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'h8000_0001);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'h8000_0000);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'd3);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'h5555_5555);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'hAAAA_AAAA);
    send_cmd(pcg32_pkg::CMD_NOP, 32'hFFFF_FFFF);
    send_cmd(pcg32_pkg::CMD_RAW, 32'd0);
    send_cmd(pcg32_pkg::CMD_RESEED, 32'd0);
    send_cmd(pcg32_pkg::CMD_RAW, 32'd0);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'd7);
    wait_idle();
    write_reg(ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ADDR_STREAM, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(pcg32_pkg::CMD_RESEED, 32'd0);
    send_cmd(pcg32_pkg::CMD_RAW, 32'd0);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'd0);
    send_cmd(pcg32_pkg::CMD_BOUNDED, 32'd1);

    // Random phases, each with its own register setting and idle pattern.
    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          write_reg(ADDR_SEED, 64'd0);
          write_reg(ADDR_STREAM, 64'd0);
        end
        1: begin
          idle_pct = 64;
          stall_pct = 0;
          write_reg(ADDR_SEED, {$urandom(), $urandom()});
          write_reg(ADDR_STREAM, 64'h7FFF_FFFF_FFFF_FFFF);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 64;
          write_reg(ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(ADDR_STREAM, {$urandom(), $urandom()});
        end
        default: begin
          idle_pct = 25;
          stall_pct = 25;
          write_reg(ADDR_SEED, {$urandom(), $urandom()});
          write_reg(ADDR_STREAM, {$urandom(), $urandom()});
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 8) cmd = pcg32_pkg::CMD_RESEED;
        else if (roll < 12) cmd = pcg32_pkg::CMD_NOP;
        else if (roll < 50) cmd = pcg32_pkg::CMD_RAW;
        else cmd = pcg32_pkg::CMD_BOUNDED;
        if (cmd != pcg32_pkg::CMD_NOP) sent++;
        send_cmd(cmd, pick_bound());
      end
    end

    // Wind down and report.
    wait_idle();
    $display("Checked %0d results: %0d raw draws, %0d bounded draws (%0d with a zero bound).",
             sb.n_checked, sb.n_raw, sb.n_bounded, sb.n_zero);
    $display("Ran %0d reseeds over five register settings and four idle/stall patterns.",
             sb.n_reseed);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
